>>> rtl/core/sli_pkg.sv
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and constants for the ordered sequence store.
// ----------------------------------------------------------------------------
package sli_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 5;

    typedef enum logic [1:0] {
        ACT_APPEND    = 2'd0,
        ACT_POP_HEAD  = 2'd1,
        ACT_POP_TAIL  = 2'd2,
        ACT_REMOVE_AT = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Broadcast to every cell: write at the index, or remove at the index
    // and close the gap from above.
    typedef struct packed {
        logic wr;
        logic rm;
    } t_req;

endpackage

>>> rtl/core/sli_cell.sv
// ----------------------------------------------------------------------------
// sli_cell
// One storage cell of the chain: holds, loads the new item or takes the
// value of its upper neighbour.
// ----------------------------------------------------------------------------
module sli_cell
    import sli_pkg::*;
#(
    parameter int IDX_W   = 4,
    parameter int CELL_ID = 0
) (
    input  logic             i_clk,
    input  t_req             i_req,
    input  logic [IDX_W-1:0] i_idx,
    input  logic [VAL_W-1:0] i_din,
    input  logic [VAL_W-1:0] i_next,
    output logic [VAL_W-1:0] o_value,
    output logic [VAL_W-1:0] o_pick
);

    localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_ID);

    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] n_value;
    logic             hit;

    assign hit = (i_idx == MyIdx);

    always_comb begin
        n_value = r_value;
        if (i_req.wr && hit) begin
            n_value = i_din;
        end else if (i_req.rm && (MyIdx >= i_idx)) begin
            n_value = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_pick  = (i_req.rm && hit) ? r_value : '0;

endmodule

>>> rtl/core/sli_ctrl.sv
// ----------------------------------------------------------------------------
// sli_ctrl
// Entry count and request decode: status, target index and cell command.
// ----------------------------------------------------------------------------
module sli_ctrl
    import sli_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  t_action          i_action,
    input  logic [POS_W-1:0] i_position,
    output t_req             o_req,
    output logic [IDX_W-1:0] o_idx,
    output t_status          o_status,
    output logic [CNT_W-1:0] o_count
);

    localparam int               CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] Full  = CNT_W'(DEPTH);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] cnt_x;
    logic             empty;

    assign pos_x = CMP_W'(i_position);
    assign cnt_x = CMP_W'(r_count);
    assign empty = (r_count == '0);

    always_comb begin
        o_req    = '0;
        o_idx    = '0;
        o_status = ST_OK;
        n_count  = r_count;
        if (i_accept) begin
            unique case (i_action)
                ACT_APPEND: begin
                    if (r_count == Full) begin
                        o_status = ST_FULL;
                    end else begin
                        o_req.wr = 1'b1;
                        o_idx    = IDX_W'(r_count);
                        n_count  = r_count + 1'b1;
                    end
                end
                ACT_POP_HEAD: begin
                    if (empty) begin
                        o_status = ST_EMPTY;
                    end else begin
                        o_req.rm = 1'b1;
                        n_count  = r_count - 1'b1;
                    end
                end
                ACT_POP_TAIL: begin
                    if (empty) begin
                        o_status = ST_EMPTY;
                    end else begin
                        o_req.rm = 1'b1;
                        o_idx    = IDX_W'(r_count - 1'b1);
                        n_count  = r_count - 1'b1;
                    end
                end
                ACT_REMOVE_AT: begin
                    if (empty) begin
                        o_status = ST_EMPTY;
                    end else if ((pos_x == '0) || (pos_x > cnt_x)) begin
                        o_status = ST_RANGE;
                    end else begin
                        o_req.rm = 1'b1;
                        o_idx    = IDX_W'(pos_x - 1'b1);
                        n_count  = r_count - 1'b1;
                    end
                end
                default: begin
                    o_status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = n_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Full)
        else $error("entry count beyond depth");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (i_action == ACT_APPEND) && (r_count != Full))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("append did not grow the count");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.rm |=> (r_count == $past(r_count) - 1'b1))
        else $error("removal did not shrink the count");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_count))
        else $error("count changed without an item");

    a_flag_no_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_status != ST_OK) |-> ((o_req == '0) && (n_count == r_count)))
        else $error("flagged request changed the store");

endmodule

>>> rtl/core/sequence_list_insert_delete.sv
// ----------------------------------------------------------------------------
// sequence_list_insert_delete
// Ordered store of signed values with append and head, tail and positional
// removal, built as a chain of shifting cells.
// ----------------------------------------------------------------------------
// Channel  Dir  tuser            tdata (lowest bit up)
// s_axis   in   action[1:0]      value[31:0], position[4:0], zero fill
// m_axis   out  status[1:0]      count[CNT_W-1:0], removed_value[31:0], fill
//
// All cells decide in parallel to hold, load or shift, and one item is taken
// in each cycle unless a full, unaccepted output register stalls the input.
// The result is seen in the cycle after the item is taken, in a single output register.
// A stalled result holds the input only while the output register is full.
// Reset empties the store at once; cell contents are not cleared.
// ----------------------------------------------------------------------------
module sequence_list_insert_delete
    import sli_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1),
    parameter int OUT_W = ((CNT_W + VAL_W + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // value, position, zero fill
    input  logic [((VAL_W+POS_W+7)/8)*8-1:0] s_axis_tdata,
    // action
    input  logic [1:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // count, removed_value, zero fill
    output logic [OUT_W-1:0]                 m_axis_tdata,
    // status
    output logic [1:0]                       m_axis_tuser
);

    logic             accept;
    t_req             req;
    logic [IDX_W-1:0] idx;
    t_status          status;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] din;
    logic [VAL_W-1:0] cell_value [DEPTH];
    logic [VAL_W-1:0] cell_pick  [DEPTH];
    logic [VAL_W-1:0] removed;

    logic             r_valid;
    t_status          r_status;
    logic [CNT_W-1:0] r_count;
    logic [VAL_W-1:0] r_removed;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign din           = s_axis_tdata[VAL_W-1:0];

    sli_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_action   (t_action'(s_axis_tuser)),
        .i_position (s_axis_tdata[VAL_W +: POS_W]),
        .o_req      (req),
        .o_idx      (idx),
        .o_status   (status),
        .o_count    (count)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        sli_cell #(
            .IDX_W   (IDX_W),
            .CELL_ID (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_req   (req),
            .i_idx   (idx),
            .i_din   (din),
            .i_next  ((g == DEPTH - 1) ? cell_value[g] : cell_value[(g + 1) % DEPTH]),
            .o_value (cell_value[g]),
            .o_pick  (cell_pick[g])
        );
    end

    always_comb begin
        removed = '0;
        for (int i = 0; i < DEPTH; i++) begin
            removed = removed | cell_pick[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= status;
            r_count   <= count;
            r_removed <= removed;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = OUT_W'({r_removed, r_count});

endmodule
